@@ design/traffic_phase_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Traffic phase controller assertion macros
// Shared concurrent assertion forms used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_PHASE_CONTROLLER_ASSERT_SVH
`define TRAFFIC_PHASE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Traffic phase controller package
// Phase, lamp and request codes plus the state, configuration and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int unsigned DurW = 16;

  typedef enum logic [2:0] {
    PH_NS_GREEN  = 3'd0,
    PH_NS_YELLOW = 3'd1,
    PH_ALL_RED_A = 3'd2,
    PH_EW_GREEN  = 3'd3,
    PH_EW_YELLOW = 3'd4,
    PH_ALL_RED_B = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    LAMP_RED    = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2
  } lamp_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_EMERG = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Approaches at or above this code are on the east-west road.
  localparam logic [1:0] EW_APPROACH_MIN = 2'd2;

  localparam logic [1:0] CFG_NORMAL_GREEN = 2'd0;
  localparam logic [1:0] CFG_YELLOW       = 2'd1;
  localparam logic [1:0] CFG_ALL_RED      = 2'd2;
  localparam logic [1:0] CFG_EMERGENCY    = 2'd3;

  localparam logic [DurW-1:0] RST_NORMAL_GREEN = 16'd10000;
  localparam logic [DurW-1:0] RST_YELLOW       = 16'd3000;
  localparam logic [DurW-1:0] RST_ALL_RED      = 16'd1000;
  localparam logic [DurW-1:0] RST_EMERGENCY    = 16'd15000;

  typedef struct packed {
    logic [DurW-1:0] yellow_ms;
    logic [DurW-1:0] all_red_ms;
    logic [DurW-1:0] emergency_ms;
  } tpc_cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [DurW-1:0] phase_elapsed;
    logic [DurW-1:0] green_dur;
    logic            ovr_on;
    logic            ovr_ew;
    logic [DurW-1:0] ovr_elapsed;
  } tpc_state_t;

  typedef struct packed {
    phase_e phase;
    lamp_e  ns_light;
    lamp_e  ew_light;
    logic   emergency_active;
    logic   phase_changed;
  } tpc_result_t;

  function automatic logic [DurW-1:0] sat_inc(input logic [DurW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

@@ design/tpc_if.sv @@
// ----------------------------------------------------------------------------
// Traffic phase controller channels
// Valid/ready channels for request items and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  approach;
  logic [15:0] green_ms;

  modport source (output valid, kind, approach, green_ms, input ready);
  modport sink   (input valid, kind, approach, green_ms, output ready);
endinterface

interface tpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic [1:0] ns_light;
  logic [1:0] ew_light;
  logic       emergency_active;
  logic       phase_changed;

  modport source (output valid, phase, ns_light, ew_light, emergency_active, phase_changed,
                  input ready);
  modport sink   (input valid, phase, ns_light, ew_light, emergency_active, phase_changed,
                  output ready);
endinterface

@@ design/tpc_step.sv @@
// ----------------------------------------------------------------------------
// Traffic phase controller step
// Next state and result for one request item, given the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpc_step (
  input  tpc_pkg::tpc_state_t  state_i,
  input  tpc_pkg::tpc_cfg_t    cfg_i,
  input  logic [1:0]           kind_i,
  input  logic [1:0]           approach_i,
  input  logic [15:0]          green_ms_i,
  output tpc_pkg::tpc_state_t  state_o,
  output tpc_pkg::tpc_result_t result_o
);
  import tpc_pkg::*;

  logic [DurW-1:0] phase_cnt;
  logic [DurW-1:0] ovr_cnt;
  logic [DurW-1:0] duration;
  phase_e          phase_nxt;
  logic            changed;

  assign phase_cnt = sat_inc(state_i.phase_elapsed);
  assign ovr_cnt   = sat_inc(state_i.ovr_elapsed);

  always_comb begin
    case (state_i.phase)
      PH_NS_GREEN, PH_EW_GREEN:   duration = state_i.green_dur;
      PH_NS_YELLOW, PH_EW_YELLOW: duration = cfg_i.yellow_ms;
      default:                    duration = cfg_i.all_red_ms;
    endcase
  end

  always_comb begin
    case (state_i.phase)
      PH_NS_GREEN:  phase_nxt = PH_NS_YELLOW;
      PH_NS_YELLOW: phase_nxt = PH_ALL_RED_A;
      PH_ALL_RED_A: phase_nxt = PH_EW_GREEN;
      PH_EW_GREEN:  phase_nxt = PH_EW_YELLOW;
      PH_EW_YELLOW: phase_nxt = PH_ALL_RED_B;
      default:      phase_nxt = PH_NS_GREEN;
    endcase
  end

  always_comb begin
    state_o = state_i;
    changed = 1'b0;
    case (kind_e'(kind_i))
      KIND_TICK: begin
        if (state_i.ovr_on) begin
          state_o.ovr_elapsed = ovr_cnt;
          if (ovr_cnt >= cfg_i.emergency_ms) begin
            state_o.ovr_on        = 1'b0;
            state_o.phase         = PH_NS_GREEN;
            state_o.phase_elapsed = '0;
            changed               = 1'b1;
          end
        end else begin
          state_o.phase_elapsed = phase_cnt;
          if (phase_cnt >= duration) begin
            state_o.phase         = phase_nxt;
            state_o.phase_elapsed = '0;
            changed               = 1'b1;
            // The request's green time is latched on entry to either green phase.
            if (phase_nxt == PH_NS_GREEN || phase_nxt == PH_EW_GREEN) begin
              state_o.green_dur = green_ms_i;
            end
          end
        end
      end
      KIND_EMERG: begin
        state_o.ovr_on      = 1'b1;
        state_o.ovr_ew      = (approach_i >= EW_APPROACH_MIN);
        state_o.ovr_elapsed = '0;
        changed             = 1'b1;
      end
      KIND_CLEAR: begin
        if (state_i.ovr_on) begin
          state_o.ovr_on        = 1'b0;
          state_o.phase         = PH_NS_GREEN;
          state_o.phase_elapsed = '0;
          changed               = 1'b1;
        end
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_o.phase            = state_o.phase;
    result_o.emergency_active = state_o.ovr_on;
    result_o.phase_changed    = changed;
    if (state_o.ovr_on) begin
      result_o.ns_light = state_o.ovr_ew ? LAMP_RED : LAMP_GREEN;
      result_o.ew_light = state_o.ovr_ew ? LAMP_GREEN : LAMP_RED;
    end else begin
      case (state_o.phase)
        PH_NS_GREEN: begin
          result_o.ns_light = LAMP_GREEN;
          result_o.ew_light = LAMP_RED;
        end
        PH_NS_YELLOW: begin
          result_o.ns_light = LAMP_YELLOW;
          result_o.ew_light = LAMP_RED;
        end
        PH_EW_GREEN: begin
          result_o.ns_light = LAMP_RED;
          result_o.ew_light = LAMP_GREEN;
        end
        PH_EW_YELLOW: begin
          result_o.ns_light = LAMP_RED;
          result_o.ew_light = LAMP_YELLOW;
        end
        default: begin
          result_o.ns_light = LAMP_RED;
          result_o.ew_light = LAMP_RED;
        end
      endcase
    end
  end

endmodule

@@ design/traffic_phase_controller.sv @@
// ----------------------------------------------------------------------------
// Traffic phase controller
// Six-phase two-road signal sequencer with emergency override.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per transfer: a one-millisecond tick, an
//   emergency request for an approach, or a clear request. Each request
//   yields exactly one result transfer on out_o with the phase, both lamp
//   states, the override flag and a change flag.
//   A request's result is written into the output register at the edge that
//   takes the request. Throughput is one request per cycle while the
//   receiver takes results, set by the single state update between the
//   request and the output register.
//   When the receiver stalls, the output register holds its result and
//   in_i.ready drops until that result is taken; a request is taken in the
//   same cycle that the held result leaves.
//   Reset clears the output valid flag and starts at north-south green with
//   the register defaults. Registers must be written through cfg_we_i only
//   while no result is pending; the block does not enforce it. A write of
//   normal green reloads the current green duration if no request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "traffic_phase_controller_assert.svh"

module traffic_phase_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  tpc_in_if.sink       in_i,
  tpc_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  import tpc_pkg::*;

  tpc_cfg_t    cfg_q;
  tpc_state_t  state_q, state_d;
  tpc_result_t result_q, result_d;
  logic        out_valid_q;
  logic        in_xfer;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  tpc_step u_step (
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .kind_i     (in_i.kind),
    .approach_i (in_i.approach),
    .green_ms_i (in_i.green_ms),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yellow_ms     <= RST_YELLOW;
      cfg_q.all_red_ms    <= RST_ALL_RED;
      cfg_q.emergency_ms  <= RST_EMERGENCY;
      state_q.phase         <= PH_NS_GREEN;
      state_q.phase_elapsed <= '0;
      state_q.green_dur     <= RST_NORMAL_GREEN;
      state_q.ovr_on        <= 1'b0;
      state_q.ovr_ew        <= 1'b0;
      state_q.ovr_elapsed   <= '0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end else if (cfg_we_i && cfg_idx_i == CFG_NORMAL_GREEN) begin
        state_q.green_dur <= cfg_data_i;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_YELLOW:    cfg_q.yellow_ms    <= cfg_data_i;
          CFG_ALL_RED:   cfg_q.all_red_ms   <= cfg_data_i;
          CFG_EMERGENCY: cfg_q.emergency_ms <= cfg_data_i;
          default:       cfg_q <= cfg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.phase            = result_q.phase;
  assign out_o.ns_light         = result_q.ns_light;
  assign out_o.ew_light         = result_q.ew_light;
  assign out_o.emergency_active = result_q.emergency_active;
  assign out_o.phase_changed    = result_q.phase_changed;

  `TPC_ASSERT_NOW(a_no_take_when_full, clk_i, rst_ni, out_valid_q && !out_o.ready, !in_xfer, "request taken while result stalled")
  `TPC_ASSERT_NEXT(a_emerg_result, clk_i, rst_ni, in_xfer && in_i.kind == KIND_EMERG, out_valid_q && result_q.emergency_active && result_q.phase_changed, "emergency request did not raise override")
  `TPC_ASSERT_NOW(a_override_one_green, clk_i, rst_ni, out_valid_q && result_q.emergency_active, (result_q.ns_light == LAMP_GREEN) != (result_q.ew_light == LAMP_GREEN), "override must light exactly one road green")
  `TPC_ASSERT_NOW(a_no_conflict, clk_i, rst_ni, out_valid_q, result_q.ns_light == LAMP_RED || result_q.ew_light == LAMP_RED, "both roads shown non-red")

endmodule

@@ test/tb_traffic_phase_controller.sv @@
// ----------------------------------------------------------------------------
// Traffic phase controller testbench
// Sends tick, emergency and clear requests through the request channel and
// checks every result transfer against a cycle-free model of the phase
// sequencer. The run goes through several register settings, from all zero
// to all ones. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_traffic_phase_controller;

  import tpc_pkg::*;

  // The request kind that the block ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] APPR_NORTH = 2'd0;
  localparam logic [1:0] APPR_SOUTH = 2'd1;
  localparam logic [1:0] APPR_EAST  = 2'd2;
  localparam logic [1:0] APPR_WEST  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  approach;
    logic [15:0] green_ms;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  tpc_in_if  req_ch ();
  tpc_out_if res_ch ();

  traffic_phase_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  request_t    pending_requests[$];
  tpc_result_t expected_lights[$];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int          mismatch_count;
  logic        req_taken;

  // Shadow copy of the controller state and its registers.
  phase_e      sig_phase;
  logic [15:0] sig_elapsed;
  logic [15:0] sig_green;
  logic        ovr_on;
  logic        ovr_ew;
  logic [15:0] ovr_elapsed;
  logic [15:0] reg_yellow;
  logic [15:0] reg_all_red;
  logic [15:0] reg_emergency;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] count_up(input logic [15:0] v);
    count_up = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic restart_sequence();
    ovr_on      = 1'b0;
    sig_phase   = PH_NS_GREEN;
    sig_elapsed = '0;
  endtask

  // Applies one request to the shadow state and returns the lights it shows.
  task automatic step_signal(input request_t req, output tpc_result_t res);
    logic        changed;
    logic [15:0] dur;
    changed = 1'b0;
    case (req.kind)
      KIND_TICK: begin
        if (ovr_on) begin
          ovr_elapsed = count_up(ovr_elapsed);
          if (ovr_elapsed >= reg_emergency) begin
            restart_sequence();
            changed = 1'b1;
          end
        end else begin
          sig_elapsed = count_up(sig_elapsed);
          case (sig_phase)
            PH_NS_GREEN, PH_EW_GREEN:   dur = sig_green;
            PH_NS_YELLOW, PH_EW_YELLOW: dur = reg_yellow;
            default:                    dur = reg_all_red;
          endcase
          if (sig_elapsed >= dur) begin
            sig_phase   = (sig_phase == PH_ALL_RED_B) ? PH_NS_GREEN : phase_e'(sig_phase + 3'd1);
            sig_elapsed = '0;
            if (sig_phase == PH_NS_GREEN || sig_phase == PH_EW_GREEN) begin
              sig_green = req.green_ms;
            end
            changed = 1'b1;
          end
        end
      end
      KIND_EMERG: begin
        ovr_on      = 1'b1;
        ovr_ew      = (req.approach >= EW_APPROACH_MIN);
        ovr_elapsed = '0;
        changed     = 1'b1;
      end
      KIND_CLEAR: begin
        if (ovr_on) begin
          restart_sequence();
          changed = 1'b1;
        end
      end
      default: ;
    endcase

    res.phase            = sig_phase;
    res.emergency_active = ovr_on;
    res.phase_changed    = changed;
    if (ovr_on) begin
      res.ns_light = ovr_ew ? LAMP_RED : LAMP_GREEN;
      res.ew_light = ovr_ew ? LAMP_GREEN : LAMP_RED;
    end else begin
      res.ns_light = LAMP_RED;
      res.ew_light = LAMP_RED;
      case (sig_phase)
        PH_NS_GREEN:  res.ns_light = LAMP_GREEN;
        PH_NS_YELLOW: res.ns_light = LAMP_YELLOW;
        PH_EW_GREEN:  res.ew_light = LAMP_GREEN;
        PH_EW_YELLOW: res.ew_light = LAMP_YELLOW;
        default: ;
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Request driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    request_t req;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(99, 0) >= send_gap_pct) begin
        req = pending_requests.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= req.kind;
        req_ch.approach <= req.approach;
        req_ch.green_ms <= req.green_ms;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Monitor: predicts on each request transfer, then checks each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t    req;
    tpc_result_t want;
    if (!rst_ni) begin
      req_taken        <= 1'b0;
      reg_yellow       = RST_YELLOW;
      reg_all_red      = RST_ALL_RED;
      reg_emergency    = RST_EMERGENCY;
      sig_phase        = PH_NS_GREEN;
      sig_elapsed      = '0;
      sig_green        = RST_NORMAL_GREEN;
      ovr_on           = 1'b0;
      ovr_ew           = 1'b0;
      ovr_elapsed      = '0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NORMAL_GREEN: sig_green = cfg_data_i;
          CFG_YELLOW:    reg_yellow = cfg_data_i;
          CFG_ALL_RED:   reg_all_red = cfg_data_i;
          CFG_EMERGENCY: reg_emergency = cfg_data_i;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        req.kind     = req_ch.kind;
        req.approach = req_ch.approach;
        req.green_ms = req_ch.green_ms;
        step_signal(req, want);
        expected_lights.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_lights.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = expected_lights.pop_front();
          if (res_ch.phase !== want.phase)
            report_mismatch($sformatf("phase got %0d want %0d", res_ch.phase, want.phase));
          if (res_ch.ns_light !== want.ns_light)
            report_mismatch($sformatf("ns_light got %0d want %0d",
                                      res_ch.ns_light, want.ns_light));
          if (res_ch.ew_light !== want.ew_light)
            report_mismatch($sformatf("ew_light got %0d want %0d",
                                      res_ch.ew_light, want.ew_light));
          if (res_ch.emergency_active !== want.emergency_active)
            report_mismatch($sformatf("emergency_active got %0b want %0b",
                                      res_ch.emergency_active, want.emergency_active));
          if (res_ch.phase_changed !== want.phase_changed)
            report_mismatch($sformatf("phase_changed got %0b want %0b",
                                      res_ch.phase_changed, want.phase_changed));
        end
      end
    end
  end

  task automatic queue_request(input logic [1:0] kind, input logic [1:0] approach,
                               input logic [15:0] green_ms);
    request_t req;
    req.kind     = kind;
    req.approach = approach;
    req.green_ms = green_ms;
    pending_requests.push_back(req);
  endtask

  // Mostly ticks with short green times, so that the cycle keeps moving;
  // now and then a wide green value, which holds a green phase for long.
  function automatic request_t random_request();
    request_t    req;
    int unsigned roll;
    roll         = $urandom_range(99, 0);
    req.approach = 2'($urandom_range(3, 0));
    req.green_ms = ($urandom_range(199, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(6, 0));
    if (roll < 90)      req.kind = KIND_TICK;
    else if (roll < 94) req.kind = KIND_EMERG;
    else if (roll < 98) req.kind = KIND_CLEAR;
    else                req.kind = KIND_UNUSED;
    return req;
  endfunction

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_requests.size() > 0 || req_ch.valid || expected_lights.size() > 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] green, input logic [15:0] yellow,
                            input logic [15:0] all_red, input logic [15:0] emergency);
    write_reg(CFG_NORMAL_GREEN, green);
    write_reg(CFG_YELLOW, yellow);
    write_reg(CFG_ALL_RED, all_red);
    write_reg(CFG_EMERGENCY, emergency);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic run_random(input int count, input int unsigned gap_pct,
                            input int unsigned stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pending_requests.push_back(random_request());
    end
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_NORMAL_GREEN;
    cfg_data_i      = '0;
    req_ch.valid    = 1'b0;
    req_ch.kind     = KIND_TICK;
    req_ch.approach = APPR_NORTH;
    req_ch.green_ms = '0;
    res_ch.ready    = 1'b0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    mismatch_count  = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Register defaults: overrides from each approach, a restart of a running
    // override, a clear with no override and the unused request kind.
    queue_request(KIND_TICK, APPR_NORTH, 16'hFFFF);
    queue_request(KIND_EMERG, APPR_NORTH, 16'h0000);
    queue_request(KIND_TICK, APPR_SOUTH, 16'h0000);
    queue_request(KIND_CLEAR, APPR_NORTH, 16'h0000);
    queue_request(KIND_CLEAR, APPR_EAST, 16'h0000);
    queue_request(KIND_UNUSED, APPR_WEST, 16'hFFFF);
    queue_request(KIND_EMERG, APPR_WEST, 16'h0000);
    queue_request(KIND_EMERG, APPR_SOUTH, 16'h0000);
    queue_request(KIND_EMERG, APPR_EAST, 16'h0000);
    queue_request(KIND_CLEAR, APPR_WEST, 16'h0000);
    wait_drained();

    // Short timings: zero-length yellow advances on the first tick, and the
    // override runs out by itself after two ticks.
    set_timing(16'd1, 16'd0, 16'd2, 16'd2);
    for (int i = 0; i < 10; i++) begin
      queue_request(KIND_TICK, APPR_NORTH, (i % 2 == 0) ? 16'd1 : 16'd0);
    end
    queue_request(KIND_EMERG, APPR_EAST, 16'd0);
    queue_request(KIND_TICK, APPR_NORTH, 16'd0);
    queue_request(KIND_TICK, APPR_NORTH, 16'd0);
    queue_request(KIND_TICK, APPR_NORTH, 16'd0);
    wait_drained();

    set_timing(16'd3, 16'd2, 16'd1, 16'd5);
    run_random(500, 0, 0);
    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(450, 84, 0);
    set_timing(16'd2, 16'd1, 16'd3, 16'd9);
    run_random(450, 0, 84);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(80, 38, 38);
    set_timing(16'd4, 16'd3, 16'd2, 16'd12);
    run_random(400, 38, 38);

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/tpc_pkg.sv
design/tpc_if.sv
design/tpc_step.sv
design/traffic_phase_controller.sv
test/tb_traffic_phase_controller.sv
